// File: rtl/servo_packet_deframer_assert.svh
// ----------------------------------------------------------------------------
// Servo packet deframer assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_PACKET_DEFRAMER_ASSERT_SVH
`define SERVO_PACKET_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spd assertion failed");

`endif

// File: rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// Servo packet deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] SPD_HDR_BYTE = 8'hFF;
  localparam logic [7:0] SPD_MIN_LEN  = 8'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CSUM_ERR  = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_TIMEOUT   = 2'd3
  } spd_status_t;

  typedef enum logic [6:0] {
    PH_HUNT0 = 7'b0000001,
    PH_HUNT1 = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } spd_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout_flag;
  } spd_item_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  data;
    logic [7:0]  servo_id;
    logic [7:0]  servo_error;
    spd_status_t status;
  } spd_result_t;

endpackage

// File: rtl/spd_in_stage.sv
// ----------------------------------------------------------------------------
// Servo packet deframer input register
// Holds one received beat until the frame logic consumes it.
// ----------------------------------------------------------------------------
module spd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spd_pkg::spd_item_t in_item,
  input  logic               advance,
  output logic               item_vld,
  output spd_pkg::spd_item_t item
);
  import spd_pkg::*;

  logic      vld_r, vld_nxt;
  spd_item_t item_r;
  logic      load;

  // A new beat may enter when the register is empty or is being drained.
  assign in_ready = !vld_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: rtl/spd_frame_fsm.sv
// ----------------------------------------------------------------------------
// Servo packet deframer frame state machine
// Tracks header, id, length, error, payload and checksum, one byte a step.
// ----------------------------------------------------------------------------
`include "servo_packet_deframer_assert.svh"

module spd_frame_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  spd_pkg::spd_item_t   item,
  output logic                 res_vld,
  output spd_pkg::spd_result_t res
);
  import spd_pkg::*;

  spd_phase_t phase_r, phase_nxt;
  logic [7:0] frame_id_r, frame_id_nxt;
  logic [7:0] frame_len_r, frame_len_nxt;
  logic [7:0] frame_err_r, frame_err_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] left_r, left_nxt;
  logic       emit;
  logic       end_flag;
  logic [7:0] data_out;
  spd_status_t status_out;
  logic [7:0] b;

  assign b = item.rx_byte;

  always_comb begin
    phase_nxt     = phase_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    frame_err_nxt = frame_err_r;
    sum_nxt       = sum_r;
    left_nxt      = left_r;
    emit          = 1'b0;
    end_flag      = 1'b0;
    data_out      = 8'd0;
    status_out    = ST_OK;
    if (item.timeout_flag) begin
      // A timeout only reports once a full header has been seen.
      phase_nxt = PH_HUNT0;
      if (phase_r != PH_HUNT0 && phase_r != PH_HUNT1) begin
        emit       = 1'b1;
        end_flag   = 1'b1;
        status_out = ST_TIMEOUT;
      end
    end else begin
      case (phase_r)
        PH_HUNT1: begin
          if (b == SPD_HDR_BYTE) begin
            phase_nxt     = PH_ID;
            frame_id_nxt  = 8'd0;
            frame_len_nxt = 8'd0;
            frame_err_nxt = 8'd0;
            sum_nxt       = 8'd0;
            left_nxt      = 8'd0;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_ID: begin
          frame_id_nxt = b;
          sum_nxt      = b;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          frame_len_nxt = b;
          sum_nxt       = sum_r + b;
          phase_nxt     = PH_ERR;
        end
        PH_ERR: begin
          frame_err_nxt = b;
          sum_nxt       = sum_r + b;
          left_nxt      = frame_len_r - SPD_MIN_LEN;
          if (frame_len_r < SPD_MIN_LEN) begin
            phase_nxt  = PH_HUNT0;
            emit       = 1'b1;
            end_flag   = 1'b1;
            status_out = ST_TOO_SHORT;
          end else if (frame_len_r == SPD_MIN_LEN) begin
            phase_nxt = PH_CSUM;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt  = sum_r + b;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_CSUM;
          end
          emit     = 1'b1;
          data_out = b;
        end
        PH_CSUM: begin
          phase_nxt  = PH_HUNT0;
          emit       = 1'b1;
          end_flag   = 1'b1;
          status_out = (~sum_r == b) ? ST_OK : ST_CSUM_ERR;
        end
        default: begin
          phase_nxt = (b == SPD_HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // The id and error fields reflect the bytes taken in this same step.
  always_comb begin
    res.is_end      = end_flag;
    res.data        = data_out;
    res.servo_id    = frame_id_nxt;
    res.servo_error = frame_err_nxt;
    res.status      = status_out;
  end

  assign res_vld = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_id_r  <= frame_id_nxt;
      frame_len_r <= frame_len_nxt;
      frame_err_r <= frame_err_nxt;
      sum_r       <= sum_nxt;
      left_r      <= left_nxt;
    end
  end

  `SPD_ASSERT_SAME(a_phase_onehot, 1'b1, $onehot(phase_r))
  `SPD_ASSERT_SAME(a_data_left_nonzero, phase_r == PH_DATA, left_r != 8'd0)
  `SPD_ASSERT_NEXT(a_timeout_hunts, step && item.timeout_flag, phase_r == PH_HUNT0)
  `SPD_ASSERT_SAME(a_payload_status_ok, res_vld && !res.is_end, res.status == ST_OK)

endmodule

// File: rtl/spd_out_stage.sv
// ----------------------------------------------------------------------------
// Servo packet deframer result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "servo_packet_deframer_assert.svh"

module spd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  spd_pkg::spd_result_t res,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spd_pkg::spd_result_t out_res
);
  import spd_pkg::*;

  logic        vld_r, vld_nxt;
  spd_result_t res_r;

  // Room for a new result when empty or when the held beat leaves now.
  assign space = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

  `SPD_ASSERT_SAME(a_load_has_room, load, !vld_r || out_ready)
  `SPD_ASSERT_NEXT(a_load_shows, load, vld_r)
  `SPD_ASSERT_NEXT(a_drain_empties, vld_r && out_ready && !load, !vld_r)

endmodule

// File: rtl/servo_packet_deframer.sv
// ----------------------------------------------------------------------------
// Servo packet deframer
// Splits a received byte stream into servo frames, payload and status beats.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock cycle and returns at most one result
// beat for it: a registered input stage feeds the frame state machine,
// whose one-byte update of phase, captured header fields and running
// checksum is a single short add and compare, and the result lands in an
// output register. The byte rate is set by that one-byte update; the input
// only stalls when the output register is full and not being taken.
// Payload bytes come out with is_end low; the frame end beat carries the
// status (ok, checksum mismatch, length too short or timeout abort).
module servo_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_timeout_flag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_end,
  output logic [7:0] out_data,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_servo_error,
  output logic [1:0] out_status
);
  import spd_pkg::*;

  spd_item_t   in_item;
  spd_item_t   item;
  logic        item_vld;
  logic        advance;
  logic        space;
  logic        res_vld;
  spd_result_t res;
  spd_result_t out_res;

  assign in_item.rx_byte      = in_rx_byte;
  assign in_item.timeout_flag = in_timeout_flag;

  // A held beat steps the frame logic only when a result could be stored.
  assign advance = item_vld && space;

  spd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  spd_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  spd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_is_end      = out_res.is_end;
  assign out_data        = out_res.data;
  assign out_servo_id    = out_res.servo_id;
  assign out_servo_error = out_res.servo_error;
  assign out_status      = out_res.status;

endmodule

// File: tb/tb_servo_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo packet deframer testbench
// Feeds the deframer with directed frames and then with a long run of random
// frames carrying noise, bad checksums, short lengths and timeout aborts. A
// scoreboard mirrors the frame state machine, predicts every result beat and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_servo_packet_deframer;
  import spd_pkg::*;

  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned QUIET_FROM     = DIRECTED_ITEMS + 1450;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 600000;

  // Mirrors the frame state machine and holds the result beats still owed.
  class deframe_scoreboard;
    spd_phase_t  phase;
    logic [7:0]  frame_id;
    logic [7:0]  frame_len;
    logic [7:0]  frame_err;
    logic [7:0]  running_sum;
    logic [7:0]  bytes_left;
    spd_result_t owed_q[$];
    int unsigned mismatches;
    int unsigned payload_beats;
    int unsigned end_beats[4];

    function new();
      phase         = PH_HUNT0;
      frame_id      = '0;
      frame_len     = '0;
      frame_err     = '0;
      running_sum   = '0;
      bytes_left    = '0;
      mismatches    = 0;
      payload_beats = 0;
      foreach (end_beats[i]) end_beats[i] = 0;
    endfunction

    function void owe_beat(logic is_end, logic [7:0] data, spd_status_t status);
      spd_result_t r;
      r.is_end      = is_end;
      r.data        = data;
      r.servo_id    = frame_id;
      r.servo_error = frame_err;
      r.status      = status;
      owed_q = {owed_q, r};
    endfunction

    function void note_byte(logic [7:0] b, logic timeout);
      if (timeout) begin
        // Only a frame with a complete header reports the abort.
        if (phase inside {PH_ID, PH_LEN, PH_ERR, PH_DATA, PH_CSUM})
          owe_beat(1'b1, 8'h00, ST_TIMEOUT);
        phase = PH_HUNT0;
        return;
      end
      case (phase)
        PH_HUNT1: begin
          if (b == SPD_HDR_BYTE) begin
            phase       = PH_ID;
            frame_id    = '0;
            frame_len   = '0;
            frame_err   = '0;
            running_sum = '0;
            bytes_left  = '0;
          end else begin
            phase = PH_HUNT0;
          end
        end
        PH_ID: begin
          frame_id    = b;
          running_sum = b;
          phase       = PH_LEN;
        end
        PH_LEN: begin
          frame_len   = b;
          running_sum = running_sum + b;
          phase       = PH_ERR;
        end
        PH_ERR: begin
          frame_err   = b;
          running_sum = running_sum + b;
          if (frame_len < SPD_MIN_LEN) begin
            owe_beat(1'b1, 8'h00, ST_TOO_SHORT);
            phase = PH_HUNT0;
          end else begin
            bytes_left = frame_len - SPD_MIN_LEN;
            phase      = (bytes_left != 0) ? PH_DATA : PH_CSUM;
          end
        end
        PH_DATA: begin
          running_sum = running_sum + b;
          bytes_left  = bytes_left - 8'd1;
          if (bytes_left == 0) phase = PH_CSUM;
          owe_beat(1'b0, b, ST_OK);
        end
        PH_CSUM: begin
          owe_beat(1'b1, 8'h00, (8'(~running_sum) == b) ? ST_OK : ST_CSUM_ERR);
          phase = PH_HUNT0;
        end
        default: phase = (b == SPD_HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(logic is_end, logic [7:0] data, logic [7:0] servo_id,
                             logic [7:0] servo_error, logic [1:0] status);
      spd_result_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: is_end %0b data %0h status %0d",
               is_end, data, status);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("is_end", 8'(want.is_end), 8'(is_end));
      compare_field("data", want.data, data);
      compare_field("servo_id", want.servo_id, servo_id);
      compare_field("servo_error", want.servo_error, servo_error);
      compare_field("status", 8'(want.status), 8'(status));
      if (want.is_end) end_beats[want.status]++;
      else payload_beats++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_timeout_flag = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_end;
  logic [7:0] out_data;
  logic [7:0] out_servo_id;
  logic [7:0] out_servo_error;
  logic [1:0] out_status;

  deframe_scoreboard sb;
  int unsigned item_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_odds = 4;
  int unsigned stall_odds = 4;
  int unsigned ready_hold = 0;
  bit          quiet = 1'b0;

  servo_packet_deframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_timeout_flag (in_timeout_flag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_end      (out_is_end),
    .out_data        (out_data),
    .out_servo_id    (out_servo_id),
    .out_servo_error (out_servo_error),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Both channels are sampled on the edge itself, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte, in_timeout_flag);
      if (out_valid && out_ready)
        sb.check_beat(out_is_end, out_data, out_servo_id, out_servo_error, out_status);
    end
  end

  // Receiver back-pressure: random stall bursts on out_ready.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      ready_hold = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic timeout);
    in_valid        <= 1'b1;
    in_rx_byte      <= b;
    in_timeout_flag <= timeout;
    // Ready is settled by the falling edge, so the next rising edge takes the beat.
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    item_count++;
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid        <= 1'b0;
      in_rx_byte      <= 8'($urandom);
      in_timeout_flag <= 1'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_beat(seq[i], 1'b0);
  endtask

  // One frame with random content, sometimes preceded by noise, sometimes
  // carrying a corrupted checksum or cut short by a timeout.
  task automatic send_frame();
    logic [7:0] frame_q[$];
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] sum;
    logic [7:0] pay;
    int         pick;
    int         abort_at;
    case ($urandom_range(0, 3))
      0: gap_odds = 0;
      1: gap_odds = 3;
      2: gap_odds = 8;
      default: gap_odds = 20;
    endcase
    case ($urandom_range(0, 3))
      0: stall_odds = 0;
      1: stall_odds = 3;
      2: stall_odds = 8;
      default: stall_odds = 20;
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) frame_q = {frame_q, 8'($urandom_range(0, 254))};
    id   = 8'($urandom);
    err  = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6) len = 8'($urandom_range(0, 1));
    else if (pick == 99) len = 8'($urandom_range(13, 255));
    else len = 8'($urandom_range(2, 12));
    frame_q = {frame_q, SPD_HDR_BYTE};
    frame_q = {frame_q, SPD_HDR_BYTE};
    frame_q = {frame_q, id};
    frame_q = {frame_q, len};
    frame_q = {frame_q, err};
    sum = id + len + err;
    if (len >= SPD_MIN_LEN) begin
      repeat (len - SPD_MIN_LEN) begin
        pay = 8'($urandom);
        sum = sum + pay;
        frame_q = {frame_q, pay};
      end
      sum = ~sum;
      if ($urandom_range(0, 7) == 0) sum = sum ^ 8'(1 << $urandom_range(0, 7));
      frame_q = {frame_q, sum};
    end
    abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, frame_q.size() - 1) : -1;
    foreach (frame_q[i]) begin
      if (i == abort_at) begin
        send_beat(8'($urandom), 1'b1);
        break;
      end
      send_beat(frame_q[i], 1'b0);
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("servo_packet_deframer test failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Id of 0xFF with no payload and a good checksum.
    send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFE});
    // Zero length ends the frame as too short once the error byte is in.
    send_bytes('{8'hFF, 8'hFF, 8'h12, 8'h00, 8'hA5});
    // A timeout while hunting only clears the header count.
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    // A timeout straight after the header reports an abort with empty fields.
    send_bytes('{8'hFF, 8'hFF});
    send_beat(8'h5A, 1'b1);
    // Payload at both extremes, then a wrong checksum.
    send_bytes('{8'hFF, 8'hFF, 8'h01, 8'h04, 8'hFF, 8'h00, 8'hFF, 8'h00});

    while (item_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      quiet = (item_count >= QUIET_FROM);
      send_frame();
    end
    in_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats; checked %0d payload beats and frame ends:",
             item_count, sb.payload_beats);
    $display("  ok %0d, checksum error %0d, too short %0d, timeout abort %0d.",
             sb.end_beats[ST_OK], sb.end_beats[ST_CSUM_ERR],
             sb.end_beats[ST_TOO_SHORT], sb.end_beats[ST_TIMEOUT]);
    if (sb.mismatches == 0) begin
      $display("servo_packet_deframer test passed");
    end else begin
      $display("servo_packet_deframer test failed");
    end
    $finish;
  end

endmodule
